>>> rtl/jsu_pkg.sv
// Shared types and constants for the JSON string unescaper.
package jsu_pkg;

   localparam int BYTE_W      = 8;
   localparam int MAX_OUT     = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   localparam logic [BYTE_W-1:0] CHAR_NUL       = 8'h00;
   localparam logic [BYTE_W-1:0] CHAR_BACKSLASH = 8'h5C;

   // One decoded request: up to three result bytes with their flags.
   // A count of zero means the request produced nothing.
   typedef struct packed {
      logic [1:0]                      count;
      logic [MAX_OUT-1:0][BYTE_W-1:0]  data;
      logic [MAX_OUT-1:0]              end_flags;
      logic [MAX_OUT-1:0]              bad_flags;
   } cmd_type;

endpackage

>>> rtl/jsu_channels.sv
// Valid/ready stream interfaces for the request and result channels.
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;
   logic       is_end;
   logic       bad_hex;

   modport source (output valid, output out_byte, output last, output is_end,
                   output bad_hex, input ready);
   modport sink   (input valid, input out_byte, input last, input is_end,
                   input bad_hex, output ready);
endinterface

>>> rtl/jsu_front.sv
// Front end: takes request bytes, tracks escape state, builds result commands.
module jsu_front (
   input  logic             clock,
   input  logic             reset,
   jsu_req_if.sink          req_if,
   input  logic             queue_full,
   output logic             push,
   output jsu_pkg::cmd_type push_cmd
);
   import jsu_pkg::*;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_ESCAPE = 2'd1,
      MODE_HEX    = 2'd2
   } mode_type;

   localparam logic [7:0] CHAR_N = 8'h6E;
   localparam logic [7:0] CHAR_R = 8'h72;
   localparam logic [7:0] CHAR_T = 8'h74;
   localparam logic [7:0] CHAR_B = 8'h62;
   localparam logic [7:0] CHAR_F = 8'h66;
   localparam logic [7:0] CHAR_U = 8'h75;

   // {valid, nibble}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'b0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   mode_type    mode_ff,   mode_in;
   logic [1:0]  digits_ff, digits_in;
   logic [11:0] code_ff,   code_in;

   logic        accept;
   logic [7:0]  c;
   logic [4:0]  hex;
   logic [15:0] code_full;
   cmd_type     cmd;

   assign req_if.ready = !queue_full;
   assign accept       = req_if.valid && req_if.ready;
   assign c            = req_if.in_byte;
   assign hex          = hex_decode(c);
   assign code_full    = {code_ff, hex[3:0]};

   always_comb begin
      cmd       = '0;
      mode_in   = mode_ff;
      digits_in = digits_ff;
      code_in   = code_ff;
      if (c == CHAR_NUL) begin
         if (mode_ff == MODE_HEX) begin
            cmd.count        = 2'd2;
            cmd.bad_flags[0] = 1'b1;
            cmd.end_flags[1] = 1'b1;
         end else begin
            cmd.count        = 2'd1;
            cmd.end_flags[0] = 1'b1;
         end
         mode_in   = MODE_NORMAL;
         digits_in = '0;
         code_in   = '0;
      end else begin
         unique case (mode_ff)
            MODE_ESCAPE: begin
               mode_in   = MODE_NORMAL;
               cmd.count = 2'd1;
               unique case (c)
                  CHAR_N:  cmd.data[0] = 8'h0A;
                  CHAR_R:  cmd.data[0] = 8'h0D;
                  CHAR_T:  cmd.data[0] = 8'h09;
                  CHAR_B:  cmd.data[0] = 8'h08;
                  CHAR_F:  cmd.data[0] = 8'h0C;
                  CHAR_U: begin
                     cmd.count = 2'd0;
                     mode_in   = MODE_HEX;
                     digits_in = '0;
                     code_in   = '0;
                  end
                  default: cmd.data[0] = c;
               endcase
            end
            MODE_HEX: begin
               if (!hex[4]) begin
                  cmd.count        = 2'd1;
                  cmd.bad_flags[0] = 1'b1;
                  mode_in          = MODE_NORMAL;
                  digits_in        = '0;
                  code_in          = '0;
               end else if (digits_ff == 2'd3) begin
                  // fourth digit: encode as UTF-8, code zero as C0 80
                  if (code_full == 16'h0000) begin
                     cmd.count   = 2'd2;
                     cmd.data[0] = 8'hC0;
                     cmd.data[1] = 8'h80;
                  end else if (code_full <= 16'h007F) begin
                     cmd.count   = 2'd1;
                     cmd.data[0] = {1'b0, code_full[6:0]};
                  end else if (code_full <= 16'h07FF) begin
                     cmd.count   = 2'd2;
                     cmd.data[0] = {3'b110, code_full[10:6]};
                     cmd.data[1] = {2'b10, code_full[5:0]};
                  end else begin
                     cmd.count   = 2'd3;
                     cmd.data[0] = {4'b1110, code_full[15:12]};
                     cmd.data[1] = {2'b10, code_full[11:6]};
                     cmd.data[2] = {2'b10, code_full[5:0]};
                  end
                  mode_in   = MODE_NORMAL;
                  digits_in = '0;
                  code_in   = '0;
               end else begin
                  digits_in = digits_ff + 2'd1;
                  code_in   = code_full[11:0];
               end
            end
            default: begin
               mode_in = MODE_NORMAL;
               if (c == CHAR_BACKSLASH) begin
                  mode_in = MODE_ESCAPE;
               end else begin
                  cmd.count   = 2'd1;
                  cmd.data[0] = c;
               end
            end
         endcase
      end
   end

   assign push     = accept && (cmd.count != 2'd0);
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NORMAL;
         digits_ff <= '0;
         code_ff   <= '0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         digits_ff <= digits_in;
         code_ff   <= code_in;
      end
   end

endmodule

>>> rtl/jsu_fifo.sv
// Short command queue between the front and back ends.
module jsu_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jsu_pkg::cmd_type push_cmd,
   input  logic             pop,
   output jsu_pkg::cmd_type head,
   output logic             empty,
   output logic             full
);
   import jsu_pkg::*;

   cmd_type             slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head  = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

>>> rtl/jsu_back.sv
// Back end: walks each queued command and drives one result per ready cycle.
module jsu_back (
   input  logic             clock,
   input  logic             reset,
   input  jsu_pkg::cmd_type head,
   input  logic             empty,
   output logic             pop,
   jsu_rsp_if.source        rsp_if
);
   import jsu_pkg::*;

   logic       valid_ff;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       end_ff,  end_in;
   logic       bad_ff,  bad_in;
   logic [1:0] idx_ff,  idx_in;
   logic       load;

   assign load = !empty && (!valid_ff || rsp_if.ready);

   always_comb begin
      unique case (idx_ff)
         2'd0: begin
            byte_in = head.data[0];
            end_in  = head.end_flags[0];
            bad_in  = head.bad_flags[0];
         end
         2'd1: begin
            byte_in = head.data[1];
            end_in  = head.end_flags[1];
            bad_in  = head.bad_flags[1];
         end
         2'd2: begin
            byte_in = head.data[2];
            end_in  = head.end_flags[2];
            bad_in  = head.bad_flags[2];
         end
         default: begin
            byte_in = '0;
            end_in  = 1'b0;
            bad_in  = 1'b0;
         end
      endcase
      last_in = (idx_ff == head.count - 2'd1);
      idx_in  = last_in ? 2'd0 : idx_ff + 2'd1;
   end

   assign pop = load && last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= idx_in;
         end else if (rsp_if.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
         end_ff  <= end_in;
         bad_ff  <= bad_in;
      end
   end

   assign rsp_if.valid    = valid_ff;
   assign rsp_if.out_byte = byte_ff;
   assign rsp_if.last     = last_ff;
   assign rsp_if.is_end   = end_ff;
   assign rsp_if.bad_hex  = bad_ff;

endmodule

>>> rtl/json_string_unescape.sv
// Top level of the JSON string unescaper.
// Each request carries one raw byte of a JSON string body; the block returns
// the unescaped bytes as results. The escapes \n \r \t \b \f map to control
// bytes, \uXXXX (hex digits in either case) becomes one to three bytes of
// UTF-8 with code zero sent as C0 80, and any other escaped byte is passed
// as is. A non-hex digit inside \u gives one result with bad_hex set and
// drops back to plain text. A zero byte ends the string: it returns the
// terminator (is_end set, out_byte zero), preceded by a bad_hex result if a
// \u was still open, and clears all state. A backslash directly before the
// zero is dropped; the zero still returns the terminator. The result flagged
// last closes the results of a request; a request may return none (a
// backslash, \u and its first three digits). One request is taken per clock
// while the four-entry command queue has room; results leave at one per
// clock while the receiver is ready. The result side is limited by its single
// output register, so a \u escape returning three bytes drains one byte at a
// time, hidden behind the six requests it needs. No configuration, no
// start-up sweep: the block is ready from the first clock after reset.
module json_string_unescape (
   input  logic      clock,
   input  logic      reset,
   jsu_req_if.sink   req_if,
   jsu_rsp_if.source rsp_if
);
   import jsu_pkg::*;

   // front end to queue
   logic    push;
   cmd_type push_cmd;
   logic    queue_full;

   // queue to back end
   cmd_type head;
   logic    empty;
   logic    pop;

   // decode and escape tracking
   jsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // decoupling queue: lets decoding run on while results are stalled
   jsu_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .empty    (empty),
      .full     (queue_full)
   );

   // result serialiser with registered output
   jsu_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .empty  (empty),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

endmodule

>>> verif/json_string_unescape_tb.sv
// Self-checking testbench for the JSON string unescaper: bursty requests, stalling result side.
`timescale 1ns / 1ps

module json_string_unescape_tb;
   import jsu_pkg::*;

   // Escape letters and hex digit bases, written by name below
   localparam logic [7:0] CH_N     = "n";
   localparam logic [7:0] CH_R     = "r";
   localparam logic [7:0] CH_T     = "t";
   localparam logic [7:0] CH_B     = "b";
   localparam logic [7:0] CH_F     = "f";
   localparam logic [7:0] CH_U     = "u";
   localparam logic [7:0] CH_QUOTE = "\"";
   localparam logic [7:0] CH_SLASH = "/";
   localparam logic [7:0] CH_ZERO  = "0";
   localparam logic [7:0] CH_LOWER_A = "a";
   localparam logic [7:0] CH_UPPER_A = "A";

   localparam int N_REQUESTS = 270;

   // Decoder mode; the fourth encoding never occurs
   typedef enum logic [1:0] {PLAIN_TEXT, AFTER_BACKSLASH, IN_HEX} esc_mode_type;

   typedef struct {
      logic [7:0] out_byte;
      logic       last;
      logic       is_end;
      logic       bad_hex;
   } unescaped_type;

   // Tracks the unescaper's state, holds the bytes it owes and checks what comes out.
   class unescape_tracker;
      unescaped_type pending_bytes[$];
      esc_mode_type  mode;
      logic [1:0]    digits_seen;
      logic [15:0]   code_accum;
      int            mismatches;
      int            results_checked;
      int            errors_seen;
      int            ends_seen;

      function new();
         clear_state();
         mismatches      = 0;
         results_checked = 0;
         errors_seen     = 0;
         ends_seen       = 0;
      endfunction

      function void clear_state();
         mode        = PLAIN_TEXT;
         digits_seen = '0;
         code_accum  = '0;
      endfunction

      function int nibble_of(logic [7:0] c);
         if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) return int'(c - CH_ZERO);
         if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd5) return int'(c - CH_LOWER_A) + 10;
         if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd5) return int'(c - CH_UPPER_A) + 10;
         return -1;
      endfunction

      function void push_byte(logic [7:0] b, logic end_f, logic bad_f);
         unescaped_type r;
         r.out_byte = b;
         r.last     = 1'b0;
         r.is_end   = end_f;
         r.bad_hex  = bad_f;
         pending_bytes.push_back(r);
      endfunction

      // Code zero goes out as the overlong pair so no zero byte leaks out
      function void push_utf8(logic [15:0] v);
         if (v == 16'h0000) begin
            push_byte(8'hC0, 1'b0, 1'b0);
            push_byte(8'h80, 1'b0, 1'b0);
         end else if (v <= 16'h007F) begin
            push_byte({1'b0, v[6:0]}, 1'b0, 1'b0);
         end else if (v <= 16'h07FF) begin
            push_byte({3'b110, v[10:6]}, 1'b0, 1'b0);
            push_byte({2'b10, v[5:0]}, 1'b0, 1'b0);
         end else begin
            push_byte({4'b1110, v[15:12]}, 1'b0, 1'b0);
            push_byte({2'b10, v[11:6]}, 1'b0, 1'b0);
            push_byte({2'b10, v[5:0]}, 1'b0, 1'b0);
         end
      endfunction

      // One accepted request: advance the state and queue what it owes
      function void take_request(logic [7:0] c);
         int            base;
         int            nib;
         unescaped_type r;
         base = pending_bytes.size();
         if (c == CHAR_NUL) begin
            if (mode == IN_HEX) push_byte(8'h00, 1'b0, 1'b1);
            push_byte(8'h00, 1'b1, 1'b0);
            clear_state();
         end else if (mode == AFTER_BACKSLASH) begin
            mode = PLAIN_TEXT;
            case (c)
               CH_N: push_byte(8'h0A, 1'b0, 1'b0);
               CH_R: push_byte(8'h0D, 1'b0, 1'b0);
               CH_T: push_byte(8'h09, 1'b0, 1'b0);
               CH_B: push_byte(8'h08, 1'b0, 1'b0);
               CH_F: push_byte(8'h0C, 1'b0, 1'b0);
               CH_U: begin
                  mode        = IN_HEX;
                  digits_seen = '0;
                  code_accum  = '0;
               end
               default: push_byte(c, 1'b0, 1'b0);
            endcase
         end else if (mode == IN_HEX) begin
            nib = nibble_of(c);
            if (nib < 0) begin
               push_byte(8'h00, 1'b0, 1'b1);
               clear_state();
            end else begin
               code_accum = {code_accum[11:0], nib[3:0]};
               if (digits_seen == 2'd3) begin
                  push_utf8(code_accum);
                  clear_state();
               end else begin
                  digits_seen = digits_seen + 2'd1;
               end
            end
         end else if (c == CHAR_BACKSLASH) begin
            mode = AFTER_BACKSLASH;
         end else begin
            push_byte(c, 1'b0, 1'b0);
         end
         if (pending_bytes.size() > base) begin
            r      = pending_bytes.pop_back();
            r.last = 1'b1;
            pending_bytes.push_back(r);
         end
      endfunction

      task report_mismatch(string what);
         $display("mismatch at %0t: %s", $time, what);
         mismatches++;
      endtask

      task match_result(unescaped_type got);
         unescaped_type want;
         results_checked++;
         if (got.is_end === 1'b1) ends_seen++;
         if (got.bad_hex === 1'b1) errors_seen++;
         if (pending_bytes.size() == 0) begin
            report_mismatch($sformatf("result %02h with nothing owed", got.out_byte));
            return;
         end
         want = pending_bytes.pop_front();
         if (got.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
         if (got.last !== want.last)
            report_mismatch($sformatf("last %b, want %b (byte %02h)", got.last, want.last,
                                      want.out_byte));
         if (got.is_end !== want.is_end)
            report_mismatch($sformatf("is_end %b, want %b", got.is_end, want.is_end));
         if (got.bad_hex !== want.bad_hex)
            report_mismatch($sformatf("bad_hex %b, want %b", got.bad_hex, want.bad_hex));
      endtask
   endclass

   logic clock;
   logic reset;

   jsu_req_if req_ch();
   jsu_rsp_if rsp_ch();

   json_string_unescape uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   unescape_tracker tracker = new();

   int burst_left    = 0;
   int requests_sent = 0;
   int unicode_sent  = 0;
   int broken_sent   = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the block hangs or loses a result
   initial begin
      #5ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Request side is noted at the edge it is accepted; values seen here are
   // the pre-edge ones, so ordering against the block's own updates is safe.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         tracker.take_request(req_ch.in_byte);
   end

   always @(posedge clock) begin
      unescaped_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.out_byte = rsp_ch.out_byte;
         got.last     = rsp_ch.last;
         got.is_end   = rsp_ch.is_end;
         got.bad_hex  = rsp_ch.bad_hex;
         tracker.match_result(got);
      end
   end

   // Receiver: a 32-bit ready pattern, rechosen each time it wraps. Styles run
   // from always ready, through even random and mostly ready, to mostly stalled.
   initial begin
      logic [31:0] stall_pat;
      logic [4:0]  pat_pos;
      rsp_ch.ready = 1'b0;
      stall_pat    = '1;
      pat_pos      = '0;
      forever begin
         @(negedge clock);
         if (pat_pos == 5'd0) begin
            case ($urandom_range(0, 3))
               0:       stall_pat = '1;
               1:       stall_pat = $urandom;
               2:       stall_pat = $urandom | $urandom;
               default: stall_pat = $urandom & $urandom;
            endcase
         end
         rsp_ch.ready <= reset ? 1'b0 : stall_pat[pat_pos];
         pat_pos = pat_pos + 5'd1;
      end
   end

   // Called at a falling edge; returns at a falling edge once accepted and past any gap.
   // Valid stays high through a burst and drops for a random gap between bursts.
   task send_byte(input logic [7:0] c);
      logic taken;
      req_ch.valid   <= 1'b1;
      req_ch.in_byte <= c;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = req_ch.ready;
         @(negedge clock);
      end
      requests_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_ch.valid   <= 1'b0;
         req_ch.in_byte <= 8'($urandom);
         repeat ($urandom_range(1, 7)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
      end
   endtask

   // Hex digit with a random letter case
   function automatic logic [7:0] hex_char(logic [3:0] n);
      if (n < 4'd10) return CH_ZERO + n;
      return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + (n - 4'd10);
   endfunction

   task send_unicode(input logic [15:0] v);
      send_byte(CHAR_BACKSLASH);
      send_byte(CH_U);
      send_byte(hex_char(v[15:12]));
      send_byte(hex_char(v[11:8]));
      send_byte(hex_char(v[7:4]));
      send_byte(hex_char(v[3:0]));
      unicode_sent++;
   endtask

   // \u cut short by a non-hex byte or by the string end
   task send_broken_unicode();
      int         good;
      logic [7:0] junk;
      good = $urandom_range(0, 3);
      send_byte(CHAR_BACKSLASH);
      send_byte(CH_U);
      repeat (good) send_byte(hex_char(4'($urandom_range(0, 15))));
      if ($urandom_range(0, 3) == 0) begin
         junk = CHAR_NUL;
      end else begin
         do junk = 8'($urandom_range(1, 255)); while (tracker.nibble_of(junk) >= 0);
      end
      send_byte(junk);
      broken_sent++;
   endtask

   // Directed opening: a control escape, \u0000 (overlong pair), \uFfFf in
   // mixed case (three bytes), an unknown escape on the top byte value,
   // a non-hex digit straight after \u, a zero inside the digits (error then
   // terminator) and a backslash directly before the end.
   logic [7:0] opening_bytes [25] = '{
      8'h5C, 8'h6E,
      8'h5C, 8'h75, 8'h30, 8'h30, 8'h30, 8'h30,
      8'h5C, 8'h75, 8'h46, 8'h66, 8'h46, 8'h66,
      8'h5C, 8'hFF,
      8'h5C, 8'h75, 8'h47,
      8'h5C, 8'h75, 8'h31, 8'h00,
      8'h5C, 8'h00
   };

   logic [15:0] code_edges [8] = '{
      16'h0001, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hD800, 16'hDFFF, 16'hFFFF
   };

   logic [7:0] escape_letters [8] = '{
      CH_N, CH_R, CH_T, CH_B, CH_F, CH_QUOTE, CHAR_BACKSLASH, CH_SLASH
   };

   initial begin
      logic [7:0]  b;
      logic [15:0] v;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.in_byte <= 8'h00;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (opening_bytes[i]) send_byte(opening_bytes[i]);

      // Mostly well-formed text and escapes with random content; the rest is
      // raw noise that may include zeros and stray backslashes.
      while (requests_sent < N_REQUESTS) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6: begin
               do b = 8'($urandom_range(1, 255)); while (b == CHAR_BACKSLASH);
               send_byte(b);
            end
            7, 8, 9: begin
               send_byte(CHAR_BACKSLASH);
               send_byte(escape_letters[$urandom_range(0, 7)]);
            end
            10: begin
               send_byte(CHAR_BACKSLASH);
               send_byte(8'($urandom_range(1, 255)));
            end
            11, 12, 13, 14: begin
               case ($urandom_range(0, 5))
                  0:       v = 16'h0000;
                  1:       v = 16'($urandom_range(16'h0001, 16'h007F));
                  2:       v = 16'($urandom_range(16'h0080, 16'h07FF));
                  3:       v = 16'($urandom_range(16'h0800, 16'hFFFF));
                  4:       v = code_edges[$urandom_range(0, 7)];
                  default: v = 16'($urandom);
               endcase
               send_unicode(v);
            end
            15, 16: send_broken_unicode();
            17:     send_byte(CHAR_NUL);
            18: begin
               send_byte(CHAR_BACKSLASH);
               send_byte(CHAR_NUL);
            end
            default: send_byte(8'($urandom_range(0, 255)));
         endcase
      end
      req_ch.valid <= 1'b0;

      // Drain: wait until every owed result has come back, then idle
      while (tracker.pending_bytes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d requests sent (%0d \\u escapes, %0d cut short), %0d results checked",
               requests_sent, unicode_sent, broken_sent, tracker.results_checked);
      $display("%0d terminators and %0d hex errors seen, %0d mismatches",
               tracker.ends_seen, tracker.errors_seen, tracker.mismatches);
      if (tracker.mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/jsu_pkg.sv
rtl/jsu_channels.sv
rtl/jsu_front.sv
rtl/jsu_fifo.sv
rtl/jsu_back.sv
rtl/json_string_unescape.sv
verif/json_string_unescape_tb.sv
